FILE: hw/rtl/mds_pkg.sv
// ----------------------------------------------------------------------------
// mds_pkg
// Shared types and constants for the Markov distribution step block.
// ----------------------------------------------------------------------------
package mds_pkg;

  // Probability format: unsigned Q1.16, where PROB_ONE stands for 1.0.
  localparam int PROB_W = 17;
  localparam int FRAC_W = 16;
  localparam logic [PROB_W-1:0] PROB_ONE = 17'd65536;

  // Field widths of the command, position and state-count fields.
  localparam int CMD_W = 2;
  localparam int POS_W = 3;
  localparam int NUM_W = 4;

  // Default matrix dimension and the most results one command may emit.
  localparam int MAX_STATES_DEF = 8;
  localparam int MAX_OUT        = 8;

  // Command codes carried on the input channel.
  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_START = 2'd1;
  localparam logic [CMD_W-1:0] CMD_STEP  = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // write one matrix entry
    logic start;      // reset the distribution to all mass in state zero
    logic commit;     // make the freshly computed vector the current one
    logic mac_issue;  // issue one multiply-accumulate read
    logic mac_first;  // first term of a sum
    logic mac_last;   // last term of a sum, write the result
    logic emit_rd;    // read one distribution entry for output
    logic emit_ld;    // load the read entry into the output register
    logic emit_last;  // the loaded result closes the vector
  } ctl_cmd_t;

endpackage

FILE: hw/rtl/markov_distribution_step.sv
// ----------------------------------------------------------------------------
// markov_distribution_step
// Markov chain state distribution propagation with a loadable matrix.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one command per transaction in in_tuser: load a
//   matrix entry (row, col, value in in_tdata), start at state zero, or step.
//   A load gives no result. Start and step send one result transaction per
//   state in use (at most eight) on the out_ channel, state zero first, with
//   out_tlast on the final one.
//   A step runs n*n multiply-accumulates through one shared multiplier, one
//   term per cycle, where n is the number of states in use; the command is
//   taken, the sums run, the pipeline drains and the banks swap, then each
//   result is read and loaded into the output register in turn. The next
//   input transaction is taken once the last result sits in the output
//   register. cfg_wr_en writes the state count; the user must write it only
//   while idle; the block does not enforce this.
//   Reset sets the distribution to all mass in state zero and the state
//   count to eight, or to MAX_STATES if that is smaller; the matrix holds no
//   defined values until loaded. When the receiver stalls, the result waits
//   in the output register and the sequence holds until it is taken.
// ----------------------------------------------------------------------------
module markov_distribution_step #(
  parameter int MAX_STATES = mds_pkg::MAX_STATES_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // Configuration
  input  logic                      cfg_wr_en,
  input  logic [mds_pkg::NUM_W-1:0] cfg_wr_data,  // state count
  // Input channel
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [23:0]               in_tdata,     // row[2:0], col[5:3], value[22:6]
  input  logic [mds_pkg::CMD_W-1:0] in_tuser,     // command[1:0]
  // Result channel
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [23:0]               out_tdata,    // state_index[2:0], probability[19:3]
  output logic                      out_tlast
);

  localparam int IW = $clog2(MAX_STATES);

  mds_pkg::ctl_cmd_t             cmd;
  logic [IW-1:0]                 rd_idx, s_idx;
  logic [mds_pkg::NUM_W-1:0]     cnt;
  logic                          out_busy;
  logic [mds_pkg::POS_W-1:0]     out_idx;
  logic [mds_pkg::PROB_W-1:0]    out_prob;

  // Sequencing of commands, sweeps and emission.
  mds_ctrl #(
    .MAX_STATES (MAX_STATES)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_cmd      (in_tuser),
    .out_busy    (out_busy),
    .cmd         (cmd),
    .rd_idx      (rd_idx),
    .s_idx       (s_idx),
    .cnt         (cnt)
  );

  // Memories, multiply-accumulate pipeline and output register.
  mds_datapath #(
    .MAX_STATES (MAX_STATES)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .rd_idx     (rd_idx),
    .s_idx      (s_idx),
    .cnt        (cnt),
    .ld_row     (in_tdata[2:0]),
    .ld_col     (in_tdata[5:3]),
    .ld_value   (in_tdata[22:6]),
    .out_tready (out_tready),
    .out_busy   (out_busy),
    .out_valid  (out_tvalid),
    .out_idx    (out_idx),
    .out_prob   (out_prob),
    .out_last   (out_tlast)
  );

  // Pack the result fields, padded to whole bytes.
  assign out_tdata = {4'd0, out_prob, out_idx};

endmodule

FILE: hw/rtl/mds_ctrl.sv
// ----------------------------------------------------------------------------
// mds_ctrl
// Controller: decodes commands, sequences the multiply-accumulate sweep and
// the emission of the result vector, and holds the state-count register.
// ----------------------------------------------------------------------------
module mds_ctrl #(
  parameter int MAX_STATES = mds_pkg::MAX_STATES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [mds_pkg::NUM_W-1:0]   cfg_wr_data,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [mds_pkg::CMD_W-1:0]   in_cmd,
  input  logic                        out_busy,
  output mds_pkg::ctl_cmd_t           cmd,
  output logic [$clog2(MAX_STATES)-1:0] rd_idx,
  output logic [$clog2(MAX_STATES)-1:0] s_idx,
  output logic [mds_pkg::NUM_W-1:0]   cnt
);

  localparam int IW = $clog2(MAX_STATES);
  localparam int CW = (IW > mds_pkg::NUM_W) ? IW : mds_pkg::NUM_W;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_MAC     = 3'd1;
  localparam logic [2:0] ST_DRAIN   = 3'd2;
  localparam logic [2:0] ST_COMMIT  = 3'd3;
  localparam logic [2:0] ST_EMIT    = 3'd4;
  localparam logic [2:0] ST_EMIT_LD = 3'd5;

  logic [2:0]                state_r, state_nxt;
  logic [CW-1:0]             i_r, i_nxt;
  logic [CW-1:0]             s_r, s_nxt;
  logic [CW-1:0]             k_r, k_nxt;
  logic                      d_r, d_nxt;
  logic [mds_pkg::NUM_W-1:0] num_r;
  logic [mds_pkg::NUM_W-1:0] n_use;
  logic [mds_pkg::NUM_W-1:0] n_emit;
  logic                      i_end, s_end, k_end;

  // State-count register, written straight from the configuration port.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_r <= mds_pkg::NUM_W'((MAX_STATES < 8) ? MAX_STATES : 8);
    end else if (cfg_wr_en) begin
      num_r <= cfg_wr_data;
    end
  end

  // Clamp the register to the states that actually exist.
  always_comb begin
    if (num_r == '0) begin
      n_use = mds_pkg::NUM_W'(1);
    end else if (int'(num_r) > MAX_STATES) begin
      n_use = mds_pkg::NUM_W'(MAX_STATES);
    end else begin
      n_use = num_r;
    end
    if (int'(n_use) > mds_pkg::MAX_OUT) begin
      n_emit = mds_pkg::NUM_W'(mds_pkg::MAX_OUT);
    end else begin
      n_emit = n_use;
    end
  end

  assign i_end = (i_r == CW'(n_use - 1'b1));
  assign s_end = (s_r == CW'(n_use - 1'b1));
  assign k_end = (k_r == CW'(n_emit - 1'b1));

  assign in_tready = (state_r == ST_IDLE);
  assign rd_idx    = (state_r == ST_MAC) ? IW'(i_r) : IW'(k_r);
  assign s_idx     = IW'(s_r);
  assign cnt       = n_use;

  // Next-state and command decode.
  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    s_nxt     = s_r;
    k_nxt     = k_r;
    d_nxt     = d_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          case (in_cmd)
            mds_pkg::CMD_LOAD: begin
              cmd.load = 1'b1;
            end
            mds_pkg::CMD_START: begin
              cmd.start = 1'b1;
              k_nxt     = '0;
              state_nxt = ST_EMIT;
            end
            mds_pkg::CMD_STEP: begin
              i_nxt     = '0;
              s_nxt     = '0;
              state_nxt = ST_MAC;
            end
            default: begin
            end
          endcase
        end
      end
      ST_MAC: begin
        // One term per cycle: i runs fastest, s selects the destination.
        cmd.mac_issue = 1'b1;
        cmd.mac_first = (i_r == '0);
        cmd.mac_last  = i_end;
        if (i_end) begin
          i_nxt = '0;
          if (s_end) begin
            d_nxt     = 1'b0;
            state_nxt = ST_DRAIN;
          end else begin
            s_nxt = s_r + 1'b1;
          end
        end else begin
          i_nxt = i_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        // Let the last sum leave the pipeline before swapping banks.
        d_nxt = 1'b1;
        if (d_r) begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
        k_nxt      = '0;
        state_nxt  = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_busy) begin
          cmd.emit_rd = 1'b1;
          state_nxt   = ST_EMIT_LD;
        end
      end
      ST_EMIT_LD: begin
        cmd.emit_ld   = 1'b1;
        cmd.emit_last = k_end;
        if (k_end) begin
          state_nxt = ST_IDLE;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = ST_EMIT;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      i_r     <= '0;
      s_r     <= '0;
      k_r     <= '0;
      d_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      s_r     <= s_nxt;
      k_r     <= k_nxt;
      d_r     <= d_nxt;
    end
  end

endmodule

FILE: hw/rtl/mds_datapath.sv
// ----------------------------------------------------------------------------
// mds_datapath
// Datapath: transition matrix memory, double-banked distribution memory,
// the shared multiply-accumulate pipeline and the output register.
// ----------------------------------------------------------------------------
module mds_datapath #(
  parameter int MAX_STATES = mds_pkg::MAX_STATES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mds_pkg::ctl_cmd_t             cmd,
  input  logic [$clog2(MAX_STATES)-1:0] rd_idx,
  input  logic [$clog2(MAX_STATES)-1:0] s_idx,
  input  logic [mds_pkg::NUM_W-1:0]     cnt,
  input  logic [mds_pkg::POS_W-1:0]     ld_row,
  input  logic [mds_pkg::POS_W-1:0]     ld_col,
  input  logic [mds_pkg::PROB_W-1:0]    ld_value,
  input  logic                          out_tready,
  output logic                          out_busy,
  output logic                          out_valid,
  output logic [mds_pkg::POS_W-1:0]     out_idx,
  output logic [mds_pkg::PROB_W-1:0]    out_prob,
  output logic                          out_last
);

  localparam int IW = $clog2(MAX_STATES);
  localparam int AW = $clog2(MAX_STATES * MAX_STATES);
  localparam int CW = ((IW > mds_pkg::NUM_W) ? IW : mds_pkg::NUM_W) + 1;
  localparam int PW = mds_pkg::PROB_W;

  logic [PW-1:0]   mat_mem [MAX_STATES*MAX_STATES];
  logic [PW-1:0]   dist_mem [2*(1 << IW)];

  logic [AW-1:0]   ld_addr, mac_addr;
  logic            ld_ok;
  logic [PW-1:0]   ld_sat;
  logic [PW-1:0]   mat_rd_r, dist_rd_r;
  logic            bank_r, fresh_r;
  logic [mds_pkg::NUM_W-1:0] cnt_r;
  logic            v1_r, f1_r, l1_r;
  logic            v2_r, f2_r, l2_r;
  logic [IW-1:0]   s1_r, s2_r;
  logic [2*PW-1:0] prod_full;
  logic [PW:0]     prod_r;
  logic [PW-1:0]   acc_r;
  logic [PW+1:0]   acc_sum;
  logic [PW-1:0]   acc_nxt;
  logic            out_valid_r, out_last_r;
  logic [mds_pkg::POS_W-1:0] out_idx_r;
  logic [PW-1:0]   out_prob_r;

  // Matrix load: drop out-of-range positions, clip values above one.
  assign ld_ok   = (int'(ld_row) < MAX_STATES) && (int'(ld_col) < MAX_STATES);
  assign ld_sat  = (ld_value > mds_pkg::PROB_ONE) ? mds_pkg::PROB_ONE : ld_value;
  assign ld_addr = AW'(int'(ld_row) * MAX_STATES + int'(ld_col));
  assign mac_addr = AW'(int'(rd_idx) * MAX_STATES + int'(s_idx));

  always_ff @(posedge clk) begin
    if (cmd.load && ld_ok) begin
      mat_mem[ld_addr] <= ld_sat;
    end
    mat_rd_r <= mat_mem[mac_addr];
  end

  // Distribution read. The start vector and entries past the last computed
  // count are supplied here instead of being stored.
  always_ff @(posedge clk) begin
    if (fresh_r) begin
      dist_rd_r <= (rd_idx == '0) ? mds_pkg::PROB_ONE : '0;
    end else if (CW'(rd_idx) < CW'(cnt_r)) begin
      dist_rd_r <= dist_mem[{bank_r, rd_idx}];
    end else begin
      dist_rd_r <= '0;
    end
    if (v2_r && l2_r) begin
      dist_mem[{~bank_r, s2_r}] <= acc_nxt;
    end
  end

  // Bank select and start flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r  <= 1'b0;
      fresh_r <= 1'b1;
      cnt_r   <= '0;
    end else if (cmd.start) begin
      fresh_r <= 1'b1;
    end else if (cmd.commit) begin
      bank_r  <= ~bank_r;
      fresh_r <= 1'b0;
      cnt_r   <= cnt;
    end
  end

  // Multiply stage: truncated Q1.16 product.
  assign prod_full = dist_rd_r * mat_rd_r;

  // Accumulate stage with saturation at one.
  assign acc_sum = (PW+2)'(f2_r ? '0 : acc_r) + (PW+2)'(prod_r);
  assign acc_nxt = (acc_sum > (PW+2)'(mds_pkg::PROB_ONE)) ? mds_pkg::PROB_ONE
                                                           : PW'(acc_sum);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= cmd.mac_issue;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    f1_r   <= cmd.mac_first;
    l1_r   <= cmd.mac_last;
    s1_r   <= s_idx;
    f2_r   <= f1_r;
    l2_r   <= l1_r;
    s2_r   <= s1_r;
    prod_r <= prod_full[2*PW-1:mds_pkg::FRAC_W];
    if (v2_r) begin
      acc_r <= acc_nxt;
    end
  end

  // Output register, freed by the receiver's handshake.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_ld) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_ld) begin
      out_idx_r  <= mds_pkg::POS_W'(rd_idx);
      out_prob_r <= dist_rd_r;
      out_last_r <= cmd.emit_last;
    end
  end

  assign out_busy  = out_valid_r && !out_tready;
  assign out_valid = out_valid_r;
  assign out_idx   = out_idx_r;
  assign out_prob  = out_prob_r;
  assign out_last  = out_last_r;

`ifndef ASSERT_OFF
  // A result is never loaded over one the receiver has not taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_ld |-> (!out_valid_r || out_tready))
    else $error("output register overwritten while stalled");

  // Banks swap only after the accumulate pipeline has drained.
  a_commit_drained: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!v1_r && !v2_r && !cmd.mac_issue))
    else $error("bank swap while sums are in flight");

  // Every emitted probability stays within one.
  a_prob_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_prob_r <= mds_pkg::PROB_ONE))
    else $error("emitted probability above one");

  // An emission read is followed by its load in the next cycle.
  a_emit_pair: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_rd |=> cmd.emit_ld)
    else $error("emission read without load");
`endif

endmodule
